@@ sv/rbp_pkg.sv @@
// Package for the reusable block pool policy: payload structs, codes,
// controller states and the command/status structs between its modules.
// Depends on nothing.
package rbp_pkg;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RECLAIM = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;
   localparam logic [1:0] OP_SUSPEND = 2'd3;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_ZERO   = 2'd1;
   localparam logic [1:0] KIND_DECOMM = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [2:0] STAT_REUSED   = 3'd0;
   localparam logic [2:0] STAT_NEW      = 3'd1;
   localparam logic [2:0] STAT_OVERCAP  = 3'd2;
   localparam logic [2:0] STAT_OFFERBAD = 3'd3;
   localparam logic [2:0] STAT_FULL     = 3'd4;

   localparam logic [1:0] MODE_AGGR = 2'd0;
   localparam logic [1:0] MODE_CONS = 2'd1;
   localparam logic [1:0] MODE_COLD = 2'd2;

   localparam logic [2:0] ES_ACTIVE      = 3'd0;
   localparam logic [2:0] ES_RETAINED    = 3'd1;
   localparam logic [2:0] ES_PEND_FREE   = 3'd2;
   localparam logic [2:0] ES_PEND_DECOMM = 3'd3;
   localparam logic [2:0] ES_DECOMMITTED = 3'd4;
   localparam logic [2:0] ES_FREED       = 3'd5;

   localparam logic [2:0] CSR_CAP_LIMIT = 3'd0;
   localparam logic [2:0] CSR_RETAINED  = 3'd1;
   localparam logic [2:0] CSR_SOFT_REL  = 3'd2;
   localparam logic [2:0] CSR_AGGR_SUSP = 3'd3;
   localparam logic [2:0] CSR_ZERO_RECL = 3'd4;
   localparam logic [2:0] CSR_COLD_RECL = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] req_size;
      logic [4:0]  align_log2;
      logic [15:0] cadence;
      logic        offer_ok;
      logic [47:0] offer_addr;
      logic [31:0] offer_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [3:0]  block_index;
      logic [47:0] block_addr;
      logic [31:0] block_size;
      logic [1:0]  release_mode;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_ALLOC_RD, S_ALLOC_EV, S_ALLOC_NEW,
      S_RECL_RD, S_RECL_EV, S_RECL_COLD, S_TICK_START, S_TICK_DIV,
      S_TICK_CHK, S_SCAN_RD, S_SCAN_EV, S_SUSP_RD, S_SUSP_EV, S_DONE
   } fsm_type;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_FIRST, PTR_LAST, PTR_INC, PTR_DEC
   } ptr_op_type;

   typedef enum logic [2:0] {
      EM_NONE, EM_REUSE, EM_ALLOC, EM_ZERO, EM_COLD, EM_SETTLE, EM_AGGR, EM_DONE
   } emit_type;

   typedef enum logic [1:0] {
      WR_ACTIVE, WR_MARK, WR_SETTLE, WR_DECOMMIT
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      ptr_op_type ptr_op;
      emit_type   emit;
      logic       st_we;
      wr_sel_type st_sel;
      logic       alloc_new;
      logic       att_clr;
      logic       att_inc;
      logic       div_start;
      logic       div_step;
      logic       pend_clr;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       ptr_first;
      logic       ptr_last;
      logic       pend;
      logic       hit;
      logic [2:0] st;
      logic       rem_zero;
      logic       div_last;
      logic       out_free;
      logic       aggr;
      logic       zero_en;
      logic       cold_en;
   } sts_type;

endpackage

@@ sv/rbp_ctrl.sv @@
// Controller of the block pool policy: sequences each operation over the
// table one entry at a time. Depends on rbp_pkg.
module rbp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbp_pkg::sts_type sts,
   output rbp_pkg::cmd_type cmd
);

   rbp_pkg::fsm_type state_ff, state_in;
   logic pending;

   assign pending = (sts.st == rbp_pkg::ES_PEND_DECOMM) || (sts.st == rbp_pkg::ES_PEND_FREE);
   assign req_ready = (state_ff == rbp_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbp_pkg::S_IDLE: begin
            if (req_valid) state_in = rbp_pkg::S_DISPATCH;
         end
         rbp_pkg::S_DISPATCH: begin
            case (sts.op)
               rbp_pkg::OP_ALLOC: begin
                  state_in = sts.count_zero ? rbp_pkg::S_ALLOC_NEW : rbp_pkg::S_ALLOC_RD;
               end
               rbp_pkg::OP_RECLAIM: begin
                  state_in = sts.count_zero ? rbp_pkg::S_DONE : rbp_pkg::S_RECL_RD;
               end
               rbp_pkg::OP_TICK: begin
                  state_in = sts.pend ? rbp_pkg::S_TICK_START : rbp_pkg::S_DONE;
               end
               default: begin
                  if (sts.count_zero) state_in = rbp_pkg::S_DONE;
                  else if (sts.aggr) state_in = rbp_pkg::S_SUSP_RD;
                  else if (sts.pend) state_in = rbp_pkg::S_SCAN_RD;
                  else state_in = rbp_pkg::S_DONE;
               end
            endcase
         end
         rbp_pkg::S_ALLOC_RD: state_in = rbp_pkg::S_ALLOC_EV;
         rbp_pkg::S_ALLOC_EV: begin
            if (sts.hit) begin
               if (sts.out_free) state_in = rbp_pkg::S_IDLE;
            end else if (sts.ptr_last) begin
               state_in = rbp_pkg::S_ALLOC_NEW;
            end else begin
               state_in = rbp_pkg::S_ALLOC_RD;
            end
         end
         rbp_pkg::S_ALLOC_NEW: begin
            if (sts.out_free) state_in = rbp_pkg::S_IDLE;
         end
         rbp_pkg::S_RECL_RD: state_in = rbp_pkg::S_RECL_EV;
         rbp_pkg::S_RECL_EV: begin
            if (sts.st == rbp_pkg::ES_DECOMMITTED || sts.st == rbp_pkg::ES_FREED) begin
               state_in = sts.ptr_last ? rbp_pkg::S_DONE : rbp_pkg::S_RECL_RD;
            end else if (sts.st == rbp_pkg::ES_ACTIVE && sts.zero_en) begin
               if (sts.out_free) state_in = rbp_pkg::S_RECL_COLD;
            end else begin
               state_in = rbp_pkg::S_RECL_COLD;
            end
         end
         rbp_pkg::S_RECL_COLD: begin
            if (!(sts.st == rbp_pkg::ES_ACTIVE && sts.cold_en && !sts.out_free)) begin
               state_in = sts.ptr_last ? rbp_pkg::S_DONE : rbp_pkg::S_RECL_RD;
            end
         end
         rbp_pkg::S_TICK_START: state_in = rbp_pkg::S_TICK_DIV;
         rbp_pkg::S_TICK_DIV: begin
            if (sts.div_last) state_in = rbp_pkg::S_TICK_CHK;
         end
         rbp_pkg::S_TICK_CHK: begin
            if (!sts.rem_zero || sts.count_zero) state_in = rbp_pkg::S_DONE;
            else state_in = rbp_pkg::S_SCAN_RD;
         end
         rbp_pkg::S_SCAN_RD: state_in = rbp_pkg::S_SCAN_EV;
         rbp_pkg::S_SCAN_EV: begin
            if (pending) begin
               if (sts.out_free) begin
                  if (sts.op == rbp_pkg::OP_TICK || sts.ptr_first) state_in = rbp_pkg::S_DONE;
                  else state_in = rbp_pkg::S_SCAN_RD;
               end
            end else begin
               state_in = sts.ptr_first ? rbp_pkg::S_DONE : rbp_pkg::S_SCAN_RD;
            end
         end
         rbp_pkg::S_SUSP_RD: state_in = rbp_pkg::S_SUSP_EV;
         rbp_pkg::S_SUSP_EV: begin
            if (!(sts.st != rbp_pkg::ES_ACTIVE && sts.st != rbp_pkg::ES_DECOMMITTED
                  && !sts.out_free)) begin
               state_in = sts.ptr_last ? rbp_pkg::S_DONE : rbp_pkg::S_SUSP_RD;
            end
         end
         rbp_pkg::S_DONE: begin
            if (sts.out_free) state_in = rbp_pkg::S_IDLE;
         end
         default: state_in = rbp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.ptr_op = rbp_pkg::PTR_HOLD;
      cmd.emit = rbp_pkg::EM_NONE;
      cmd.st_sel = rbp_pkg::WR_ACTIVE;
      case (state_ff)
         rbp_pkg::S_IDLE: cmd.load = req_valid;
         rbp_pkg::S_DISPATCH: begin
            case (sts.op)
               rbp_pkg::OP_ALLOC: cmd.ptr_op = rbp_pkg::PTR_FIRST;
               rbp_pkg::OP_RECLAIM: begin
                  cmd.att_clr = 1'b1;
                  cmd.ptr_op = rbp_pkg::PTR_FIRST;
               end
               rbp_pkg::OP_TICK: cmd.att_inc = sts.pend;
               default: begin
                  cmd.ptr_op = sts.aggr ? rbp_pkg::PTR_FIRST : rbp_pkg::PTR_LAST;
                  cmd.pend_clr = sts.count_zero && (sts.aggr || sts.pend);
               end
            endcase
         end
         rbp_pkg::S_ALLOC_EV: begin
            if (sts.hit) begin
               if (sts.out_free) begin
                  cmd.emit = rbp_pkg::EM_REUSE;
                  cmd.st_we = 1'b1;
                  cmd.st_sel = rbp_pkg::WR_ACTIVE;
               end
            end else if (!sts.ptr_last) begin
               cmd.ptr_op = rbp_pkg::PTR_INC;
            end
         end
         rbp_pkg::S_ALLOC_NEW: begin
            if (sts.out_free) begin
               cmd.emit = rbp_pkg::EM_ALLOC;
               cmd.alloc_new = 1'b1;
            end
         end
         rbp_pkg::S_RECL_EV: begin
            if (sts.st == rbp_pkg::ES_DECOMMITTED || sts.st == rbp_pkg::ES_FREED) begin
               if (!sts.ptr_last) cmd.ptr_op = rbp_pkg::PTR_INC;
            end else if (sts.st == rbp_pkg::ES_ACTIVE && sts.zero_en && sts.out_free) begin
               cmd.emit = rbp_pkg::EM_ZERO;
            end
         end
         rbp_pkg::S_RECL_COLD: begin
            if (!(sts.st == rbp_pkg::ES_ACTIVE && sts.cold_en && !sts.out_free)) begin
               if (sts.st == rbp_pkg::ES_ACTIVE && sts.cold_en) cmd.emit = rbp_pkg::EM_COLD;
               cmd.st_we = 1'b1;
               cmd.st_sel = rbp_pkg::WR_MARK;
               if (!sts.ptr_last) cmd.ptr_op = rbp_pkg::PTR_INC;
            end
         end
         rbp_pkg::S_TICK_START: cmd.div_start = 1'b1;
         rbp_pkg::S_TICK_DIV: cmd.div_step = 1'b1;
         rbp_pkg::S_TICK_CHK: begin
            if (sts.rem_zero) begin
               cmd.pend_clr = sts.count_zero;
               cmd.ptr_op = rbp_pkg::PTR_LAST;
            end
         end
         rbp_pkg::S_SCAN_EV: begin
            if (pending) begin
               if (sts.out_free) begin
                  cmd.emit = rbp_pkg::EM_SETTLE;
                  cmd.st_we = 1'b1;
                  cmd.st_sel = rbp_pkg::WR_SETTLE;
                  if (sts.op != rbp_pkg::OP_TICK) begin
                     if (sts.ptr_first) cmd.pend_clr = 1'b1;
                     else cmd.ptr_op = rbp_pkg::PTR_DEC;
                  end
               end
            end else if (sts.ptr_first) begin
               cmd.pend_clr = 1'b1;
            end else begin
               cmd.ptr_op = rbp_pkg::PTR_DEC;
            end
         end
         rbp_pkg::S_SUSP_EV: begin
            if (sts.st != rbp_pkg::ES_ACTIVE && sts.st != rbp_pkg::ES_DECOMMITTED) begin
               if (sts.out_free) begin
                  cmd.emit = rbp_pkg::EM_AGGR;
                  cmd.st_we = 1'b1;
                  cmd.st_sel = rbp_pkg::WR_DECOMMIT;
                  if (sts.ptr_last) cmd.pend_clr = 1'b1;
                  else cmd.ptr_op = rbp_pkg::PTR_INC;
               end
            end else if (sts.ptr_last) begin
               cmd.pend_clr = 1'b1;
            end else begin
               cmd.ptr_op = rbp_pkg::PTR_INC;
            end
         end
         rbp_pkg::S_DONE: begin
            if (sts.out_free) cmd.emit = rbp_pkg::EM_DONE;
         end
         default: cmd.load = 1'b0;
      endcase
   end

endmodule

@@ sv/rbp_dp.sv @@
// Datapath of the block pool policy: configuration registers, block table
// memories, counters, remainder unit and the result register. Depends on rbp_pkg.
module rbp_dp #(
   parameter int MAX_BLOCKS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  rbp_pkg::req_type req_data,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [39:0]      csr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbp_pkg::rsp_type rsp_data,
   input  rbp_pkg::cmd_type cmd,
   output rbp_pkg::sts_type sts
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   logic [39:0] cap_limit_ff;
   logic [4:0]  retained_ff, soft_ff;
   logic        aggr_ff, zero_ff, cold_ff;

   rbp_pkg::req_type item_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [39:0]   cap_used_ff;
   logic          pend_ff;
   logic [31:0]   att_ff;
   logic [16:0]   rem_ff;
   logic [4:0]    div_cnt_ff;
   rbp_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;

   logic [47:0] addr_mem [MAX_BLOCKS];
   logic [31:0] size_mem [MAX_BLOCKS];
   logic [2:0]  st_mem   [MAX_BLOCKS];
   logic [47:0] rd_addr_ff;
   logic [31:0] rd_size_ff;
   logic [2:0]  rd_st_ff;

   logic [IW-1:0] wr_addr;
   logic [2:0]    wr_st, mark_st;
   logic [6:0]    ret_sum;
   logic [47:0]   align_mask;
   logic [40:0]   cap_check, cap_sum;
   logic          over_cap, full, grant;
   logic [2:0]    fail_code;
   logic [15:0]   cad_eff;
   logic [16:0]   rem_try;
   logic [31:0]   ptr_wide, count_wide;
   logic          out_free;
   rbp_pkg::rsp_type rsp_new;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ptr_wide   = 32'(ptr_ff);
   assign count_wide = 32'(count_ff);
   assign ret_sum    = 7'(retained_ff) + 7'(soft_ff);
   assign align_mask = (48'd1 << item_ff.align_log2) - 48'd1;
   assign cap_check  = {1'b0, cap_used_ff} + 41'(item_ff.req_size);
   assign cap_sum    = {1'b0, cap_used_ff} + 41'(item_ff.offer_size);
   assign over_cap   = (cap_limit_ff != 40'd0) && (cap_check > {1'b0, cap_limit_ff});
   assign full       = (count_ff == CW'(MAX_BLOCKS));
   assign grant      = !over_cap && !full && item_ff.offer_ok;
   assign cad_eff    = (item_ff.cadence == 16'd0) ? 16'd1 : item_ff.cadence;
   assign rem_try    = {rem_ff[15:0], att_ff[div_cnt_ff]};
   assign wr_addr    = cmd.alloc_new ? count_ff[IW-1:0] : ptr_ff;

   always_comb begin
      if (over_cap) fail_code = rbp_pkg::STAT_OVERCAP;
      else if (full) fail_code = rbp_pkg::STAT_FULL;
      else fail_code = rbp_pkg::STAT_OFFERBAD;
   end

   always_comb begin
      if (7'(ptr_ff) < 7'(retained_ff)) mark_st = rbp_pkg::ES_RETAINED;
      else if (7'(ptr_ff) < ret_sum) mark_st = rbp_pkg::ES_PEND_FREE;
      else mark_st = rbp_pkg::ES_PEND_DECOMM;
   end

   always_comb begin
      case (cmd.st_sel)
         rbp_pkg::WR_ACTIVE:   wr_st = rbp_pkg::ES_ACTIVE;
         rbp_pkg::WR_MARK:     wr_st = mark_st;
         rbp_pkg::WR_SETTLE:   wr_st = (rd_st_ff == rbp_pkg::ES_PEND_DECOMM) ?
                                       rbp_pkg::ES_DECOMMITTED : rbp_pkg::ES_FREED;
         rbp_pkg::WR_DECOMMIT: wr_st = rbp_pkg::ES_DECOMMITTED;
         default:              wr_st = rbp_pkg::ES_ACTIVE;
      endcase
   end

   always_comb begin
      case (cmd.ptr_op)
         rbp_pkg::PTR_FIRST: ptr_in = '0;
         rbp_pkg::PTR_LAST:  ptr_in = IW'(count_wide - 32'd1);
         rbp_pkg::PTR_INC:   ptr_in = ptr_ff + IW'(1);
         rbp_pkg::PTR_DEC:   ptr_in = ptr_ff - IW'(1);
         default:            ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      rsp_new = '0;
      rsp_new.block_index = ptr_wide[3:0];
      rsp_new.block_addr  = rd_addr_ff;
      rsp_new.block_size  = rd_size_ff;
      case (cmd.emit)
         rbp_pkg::EM_REUSE: begin
            rsp_new.kind   = rbp_pkg::KIND_REPLY;
            rsp_new.status = rbp_pkg::STAT_REUSED;
            rsp_new.last   = 1'b1;
         end
         rbp_pkg::EM_ALLOC: begin
            rsp_new.kind = rbp_pkg::KIND_REPLY;
            rsp_new.last = 1'b1;
            if (grant) begin
               rsp_new.status      = rbp_pkg::STAT_NEW;
               rsp_new.block_index = count_wide[3:0];
               rsp_new.block_addr  = item_ff.offer_addr;
               rsp_new.block_size  = item_ff.offer_size;
            end else begin
               rsp_new.status      = fail_code;
               rsp_new.block_index = 4'd0;
               rsp_new.block_addr  = 48'd0;
               rsp_new.block_size  = 32'd0;
            end
         end
         rbp_pkg::EM_ZERO: rsp_new.kind = rbp_pkg::KIND_ZERO;
         rbp_pkg::EM_COLD: begin
            rsp_new.kind         = rbp_pkg::KIND_DECOMM;
            rsp_new.release_mode = rbp_pkg::MODE_COLD;
         end
         rbp_pkg::EM_SETTLE: begin
            rsp_new.kind         = rbp_pkg::KIND_DECOMM;
            rsp_new.release_mode = (rd_st_ff == rbp_pkg::ES_PEND_DECOMM) ?
                                   rbp_pkg::MODE_AGGR : rbp_pkg::MODE_CONS;
         end
         rbp_pkg::EM_AGGR: begin
            rsp_new.kind         = rbp_pkg::KIND_DECOMM;
            rsp_new.release_mode = rbp_pkg::MODE_AGGR;
         end
         rbp_pkg::EM_DONE: begin
            rsp_new = '0;
            rsp_new.kind = rbp_pkg::KIND_DONE;
            rsp_new.last = 1'b1;
         end
         default: rsp_new = '0;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_limit_ff <= '0;
         retained_ff  <= '0;
         soft_ff      <= '0;
         aggr_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         cold_ff      <= 1'b0;
         count_ff     <= '0;
         cap_used_ff  <= '0;
         pend_ff      <= 1'b0;
         att_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rbp_pkg::CSR_CAP_LIMIT: cap_limit_ff <= csr_data;
               rbp_pkg::CSR_RETAINED:  retained_ff  <= csr_data[4:0];
               rbp_pkg::CSR_SOFT_REL:  soft_ff      <= csr_data[4:0];
               rbp_pkg::CSR_AGGR_SUSP: aggr_ff      <= csr_data[0];
               rbp_pkg::CSR_ZERO_RECL: zero_ff      <= csr_data[0];
               rbp_pkg::CSR_COLD_RECL: cold_ff      <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.alloc_new && grant) begin
            count_ff    <= count_ff + CW'(1);
            cap_used_ff <= cap_sum[40] ? '1 : cap_sum[39:0];
         end
         if (cmd.pend_clr) pend_ff <= 1'b0;
         else if (cmd.st_we && cmd.st_sel == rbp_pkg::WR_MARK &&
                  mark_st != rbp_pkg::ES_RETAINED) pend_ff <= 1'b1;
         if (cmd.att_clr) att_ff <= '0;
         else if (cmd.att_inc) att_ff <= att_ff + 32'd1;
         if (cmd.emit != rbp_pkg::EM_NONE) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      ptr_ff <= ptr_in;
      if (cmd.emit != rbp_pkg::EM_NONE) rsp_ff <= rsp_new;
      if (cmd.div_start) begin
         rem_ff     <= '0;
         div_cnt_ff <= 5'd31;
      end else if (cmd.div_step) begin
         rem_ff     <= (rem_try >= 17'(cad_eff)) ? rem_try - 17'(cad_eff) : rem_try;
         div_cnt_ff <= div_cnt_ff - 5'd1;
      end
   end

   // Block table.
   always_ff @(posedge clock) begin
      if (cmd.alloc_new && grant) begin
         addr_mem[wr_addr] <= item_ff.offer_addr;
         size_mem[wr_addr] <= item_ff.offer_size;
      end
      if ((cmd.alloc_new && grant) || cmd.st_we) begin
         st_mem[wr_addr] <= cmd.alloc_new ? rbp_pkg::ES_ACTIVE : wr_st;
      end
      rd_addr_ff <= addr_mem[ptr_ff];
      rd_size_ff <= size_mem[ptr_ff];
      rd_st_ff   <= st_mem[ptr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.op         = item_ff.op;
      sts.count_zero = (count_ff == '0);
      sts.ptr_first  = (ptr_ff == '0);
      sts.ptr_last   = ((CW'(ptr_ff) + CW'(1)) == count_ff);
      sts.pend       = pend_ff;
      sts.hit        = (rd_st_ff != rbp_pkg::ES_ACTIVE) && (rd_size_ff >= item_ff.req_size)
                       && ((rd_addr_ff & align_mask) == 48'd0);
      sts.st         = rd_st_ff;
      sts.rem_zero   = (rem_ff == '0);
      sts.div_last   = (div_cnt_ff == 5'd0);
      sts.out_free   = out_free;
      sts.aggr       = aggr_ff;
      sts.zero_en    = zero_ff;
      sts.cold_en    = cold_ff;
   end

endmodule

@@ sv/reusable_block_pool_policy_top.sv @@
// Top level of the reusable block pool policy: controller plus datapath.
// Depends on rbp_pkg, rbp_ctrl and rbp_dp.
//
//   Channel  Ports                                  Direction  Beat carries
//   req      req_valid, req_ready, req_data         in         one operation
//   rsp      rsp_valid, rsp_ready, rsp_data         out        one result
//   csr      csr_valid, csr_ready, csr_index/data   in         one register write
//
// One operation is taken at a time. An allocate scans the entries from the table start;
// a reclaim walks every entry; an aggressive suspend walks the entries from the
// table start; a tick that reaches the cadence check runs the bit-serial remainder
// unit, then scans entries from the table end, as does a conservative suspend.
// Reset is synchronous and active high; it empties the table and clears the
// counters and configuration. A stalled result beat holds the sequencer in place.
module reusable_block_pool_policy_top #(
   parameter int MAX_BLOCKS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [39:0]      csr_data
);

   rbp_pkg::cmd_type cmd;
   rbp_pkg::sts_type sts;

   // Register writes are to arrive only while the block is idle; the block does not enforce it and always takes them.
   assign csr_ready = 1'b1;

   rbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbp_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
